@@ rtl/dtfp_pkg.sv @@
// Shared types and constants for the decimal text to fixed-point parser.
// Used by dtfp_front, dtfp_back and decimal_text_to_fixed_parser_top; no dependencies.
package dtfp_pkg;

    // Longest accepted text in bytes; longer text reports capacity exceeded
    localparam int MAX_TEXT_LENGTH = 64;

    // Largest supported fraction scale
    localparam logic [3:0] MAX_SCALE = 4'd9;

    // Largest magnitude that can still be multiplied by ten during padding
    // (the same for both signs)
    localparam logic [63:0] PAD_LIMIT = 64'd922337203685477580;

    // Depth of the queue between front and back
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;

    // Character classes
    typedef logic [2:0] cls_t;
    localparam cls_t CLS_SPACE = 3'd0;
    localparam cls_t CLS_DIGIT = 3'd1;
    localparam cls_t CLS_POINT = 3'd2;
    localparam cls_t CLS_PLUS  = 3'd3;
    localparam cls_t CLS_MINUS = 3'd4;
    localparam cls_t CLS_OTHER = 3'd5;

    // One classified byte as it travels from front to back
    typedef struct packed {
        cls_t       cls;
        logic [3:0] digit;
        logic       last;
    } entry_t;

endpackage

@@ rtl/dtfp_front.sv @@
// Front end: classifies each incoming text byte and queues it for the back end.
// Depends on dtfp_pkg.
module dtfp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       text_byte,
    input  logic             is_last,
    output logic             head_valid,
    output dtfp_pkg::entry_t head,
    input  logic             take
);

    dtfp_pkg::entry_t                 mem_reg [dtfp_pkg::FQ_DEPTH];
    logic [dtfp_pkg::FQ_AW-1:0]       wr_ptr_reg;
    logic [dtfp_pkg::FQ_AW-1:0]       wr_ptr_next;
    logic [dtfp_pkg::FQ_AW-1:0]       rd_ptr_reg;
    logic [dtfp_pkg::FQ_AW-1:0]       rd_ptr_next;
    logic [dtfp_pkg::FQ_CW-1:0]       count_reg;
    logic [dtfp_pkg::FQ_CW-1:0]       count_next;
    logic                             wr_en;
    logic                             rd_en;
    dtfp_pkg::entry_t                 in_entry;

    function automatic dtfp_pkg::entry_t classify(input logic [7:0] b, input logic l);
        dtfp_pkg::entry_t e;
        e.digit = b[3:0];
        e.last  = l;
        unique case (b) inside
            8'h20, 8'h09: e.cls = dtfp_pkg::CLS_SPACE;
            [8'h30:8'h39]: e.cls = dtfp_pkg::CLS_DIGIT;
            8'h2E:        e.cls = dtfp_pkg::CLS_POINT;
            8'h2B:        e.cls = dtfp_pkg::CLS_PLUS;
            8'h2D:        e.cls = dtfp_pkg::CLS_MINUS;
            default:      e.cls = dtfp_pkg::CLS_OTHER;
        endcase
        return e;
    endfunction

    assign in_entry   = classify(text_byte, is_last);
    assign full       = (count_reg == dtfp_pkg::FQ_CW'(dtfp_pkg::FQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = take && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dtfp_pkg::FQ_CW'(dtfp_pkg::FQ_DEPTH))
        else $error("front queue count beyond depth");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        full && !take |=> full)
        else $error("front queue left full state without a read");

endmodule

@@ rtl/dtfp_back.sv @@
// Back end: scans classified bytes, accumulates the magnitude, pads to scale and
// holds the result word for the reader. Depends on dtfp_pkg.
module dtfp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [3:0]              frac_scale,
    input  logic                    head_valid,
    input  dtfp_pkg::entry_t        head,
    output logic                    take,
    output logic                    empty,
    input  logic                    pop,
    output logic [1:0]              status,
    output logic signed [63:0]      coefficient
);

    localparam logic BK_SCAN = 1'b0;
    localparam logic BK_FIN  = 1'b1;

    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_BODY  = 2'd1;
    localparam logic [1:0] PH_TRAIL = 2'd2;

    logic        state_reg,   state_next;
    logic [3:0]  scale_reg;
    logic [63:0] acc_reg,     acc_next;
    logic        neg_reg,     neg_next;
    logic        point_reg,   point_next;
    logic        whole_reg,   whole_next;
    logic [3:0]  frac_reg,    frac_next;
    logic [7:0]  bytes_reg,   bytes_next;
    logic [1:0]  phase_reg,   phase_next;
    logic [1:0]  err_reg,     err_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  status_reg;
    logic [63:0] coef_reg;

    logic        do_body;
    logic        can_load;
    logic        out_load;
    logic [1:0]  fin_status;
    logic        fin_done;
    logic [67:0] prod;
    logic [67:0] limit;
    logic        ovf;
    logic [63:0] times_ten;

    assign cfg_ready   = 1'b1;
    assign empty       = !out_valid_reg;
    assign status      = status_reg;
    assign coefficient = coef_reg;
    assign can_load    = !out_valid_reg || pop;

    // acc*10 + digit against the limit for the sign (2^63-1 or 2^63)
    assign prod  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {64'd0, head.digit};
    assign limit = {4'b0000, neg_reg, {63{~neg_reg}}};
    assign ovf   = (prod > limit);
    assign times_ten = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0};

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        point_next = point_reg;
        whole_next = whole_reg;
        frac_next  = frac_reg;
        bytes_next = bytes_reg;
        phase_next = phase_reg;
        err_next   = err_reg;
        take       = 1'b0;
        out_load   = 1'b0;
        do_body    = 1'b0;
        fin_done   = 1'b0;
        fin_status = dtfp_pkg::ST_OK;

        unique case (state_reg)
            BK_SCAN:
            begin
                if (head_valid)
                begin
                    take = 1'b1;
                    if (bytes_reg != 8'hFF)
                    begin
                        bytes_next = bytes_reg + 8'd1;
                    end
                    if (err_reg == dtfp_pkg::ST_OK)
                    begin
                        case (phase_reg)
                            PH_LEAD:
                            begin
                                if (head.cls != dtfp_pkg::CLS_SPACE)
                                begin
                                    phase_next = PH_BODY;
                                    if (head.cls == dtfp_pkg::CLS_PLUS ||
                                        head.cls == dtfp_pkg::CLS_MINUS)
                                    begin
                                        neg_next = (head.cls == dtfp_pkg::CLS_MINUS);
                                    end
                                    else
                                    begin
                                        do_body = 1'b1;
                                    end
                                end
                            end
                            PH_BODY:
                            begin
                                do_body = 1'b1;
                            end
                            default:
                            begin
                                if (head.cls != dtfp_pkg::CLS_SPACE)
                                begin
                                    err_next = dtfp_pkg::ST_INVALID;
                                end
                            end
                        endcase
                    end
                    if (do_body)
                    begin
                        if (head.cls == dtfp_pkg::CLS_SPACE)
                        begin
                            phase_next = PH_TRAIL;
                        end
                        else if (head.cls == dtfp_pkg::CLS_POINT && !point_reg &&
                                 whole_reg && scale_reg != 4'd0)
                        begin
                            point_next = 1'b1;
                        end
                        else if (head.cls != dtfp_pkg::CLS_DIGIT)
                        begin
                            err_next = dtfp_pkg::ST_INVALID;
                        end
                        else if (point_reg && frac_reg >= scale_reg)
                        begin
                            err_next = dtfp_pkg::ST_INVALID;
                        end
                        else if (ovf)
                        begin
                            err_next = dtfp_pkg::ST_CAPACITY;
                        end
                        else
                        begin
                            acc_next = prod[63:0];
                            if (point_reg)
                            begin
                                frac_next = frac_reg + 4'd1;
                            end
                            else
                            begin
                                whole_next = 1'b1;
                            end
                        end
                    end
                    if (head.last)
                    begin
                        state_next = BK_FIN;
                    end
                end
            end
            BK_FIN:
            begin
                // one padding digit per cycle until the scale is reached
                if (scale_reg > dtfp_pkg::MAX_SCALE)
                begin
                    fin_done   = 1'b1;
                    fin_status = dtfp_pkg::ST_INVALID;
                end
                else if (bytes_reg > 8'(dtfp_pkg::MAX_TEXT_LENGTH))
                begin
                    fin_done   = 1'b1;
                    fin_status = dtfp_pkg::ST_CAPACITY;
                end
                else if (err_reg != dtfp_pkg::ST_OK)
                begin
                    fin_done   = 1'b1;
                    fin_status = err_reg;
                end
                else if (!whole_reg || (point_reg && frac_reg == 4'd0))
                begin
                    fin_done   = 1'b1;
                    fin_status = dtfp_pkg::ST_INVALID;
                end
                else if (frac_reg < scale_reg)
                begin
                    if (acc_reg > dtfp_pkg::PAD_LIMIT)
                    begin
                        fin_done   = 1'b1;
                        fin_status = dtfp_pkg::ST_CAPACITY;
                    end
                    else
                    begin
                        acc_next  = times_ten;
                        frac_next = frac_reg + 4'd1;
                    end
                end
                else
                begin
                    fin_done = 1'b1;
                end

                if (fin_done && can_load)
                begin
                    out_load   = 1'b1;
                    state_next = BK_SCAN;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    point_next = 1'b0;
                    whole_next = 1'b0;
                    frac_next  = '0;
                    bytes_next = '0;
                    phase_next = PH_LEAD;
                    err_next   = dtfp_pkg::ST_OK;
                end
            end
            default:
            begin
                state_next = BK_SCAN;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_SCAN;
            scale_reg     <= '0;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            point_reg     <= 1'b0;
            whole_reg     <= 1'b0;
            frac_reg      <= '0;
            bytes_reg     <= '0;
            phase_reg     <= PH_LEAD;
            err_reg       <= dtfp_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            point_reg     <= point_next;
            whole_reg     <= whole_next;
            frac_reg      <= frac_next;
            bytes_reg     <= bytes_next;
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                scale_reg <= frac_scale;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= fin_status;
            coef_reg   <= (fin_status != dtfp_pkg::ST_OK) ? 64'd0 :
                          (neg_reg ? (64'd0 - acc_reg) : acc_reg);
        end
    end

    a_coef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != dtfp_pkg::ST_OK |-> coef_reg == 64'd0)
        else $error("nonzero coefficient with error status");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg[63] |-> acc_reg[62:0] == 63'd0)
        else $error("magnitude beyond 2^63");

    a_no_take_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_FIN |-> !take)
        else $error("byte taken while finishing a text");

endmodule

@@ rtl/decimal_text_to_fixed_parser_top.sv @@
// Top level of the decimal text to fixed-point parser.
// Depends on dtfp_pkg, dtfp_front and dtfp_back.
//
// Usage: text bytes enter on text_byte/is_last through push/full; a word is
// taken when push is high and full is low. One result per text (the byte
// flagged is_last ends it) leaves on status/coefficient; it is shown while
// empty is low and taken when pop is high. frac_scale is written over the
// cfg_valid/cfg_ready channel (always ready) while no text is in flight.
// Throughput: one byte per cycle while scanning. After the last byte the back
// end pads with zero digits (frac_scale minus the fraction digits given, at
// most 9), doing one multiply by ten per cycle, then loads the result once
// the output word is free. The result comes later when the front queue
// still holds bytes of earlier texts, since those are scanned first.
// A four-word queue sits between front and back, so bytes keep being taken
// while a result waits; if the reader stalls, the back end holds at the next
// text end and the queue fills, raising full.
// Reset clears the parse state, the queues and frac_scale (to zero).
module decimal_text_to_fixed_parser_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         text_byte,
    input  logic               is_last,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         status,
    output logic signed [63:0] coefficient,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         frac_scale
);

    logic             head_valid;
    dtfp_pkg::entry_t head;
    logic             take;

    dtfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .text_byte  (text_byte),
        .is_last    (is_last),
        .head_valid (head_valid),
        .head       (head),
        .take       (take)
    );

    dtfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .frac_scale  (frac_scale),
        .head_valid  (head_valid),
        .head        (head),
        .take        (take),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .coefficient (coefficient)
    );

endmodule

@@ sim/dtfp_result_checker.sv @@
// Result checker for the decimal text to fixed-point parser: watches the byte,
// result and scale channels, predicts each result and compares it. Needs dtfp_pkg.
`timescale 1ns / 100ps

module dtfp_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [7:0]         text_byte,
    input  logic               is_last,
    input  logic               empty,
    input  logic               pop,
    input  logic [1:0]         status,
    input  logic signed [63:0] coefficient,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [3:0]         frac_scale,
    output int                 mismatches,
    output int                 awaited
);

    typedef enum logic [1:0] {SCAN_LEAD, SCAN_BODY, SCAN_TRAIL} scan_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] coefficient;
    } parse_result_t;

    parse_result_t parsed_q[$];

    logic [3:0]  scale_cfg;
    logic [63:0] mag;
    logic        neg;
    logic        seen_pt;
    logic        has_whole;
    logic [3:0]  frac_cnt;
    logic [7:0]  byte_cnt;
    scan_t       phase;
    logic [1:0]  err;

    function automatic logic [63:0] sign_cap();
        return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    endfunction

    task automatic clear_text();
        mag       = '0;
        neg       = 1'b0;
        seen_pt   = 1'b0;
        has_whole = 1'b0;
        frac_cnt  = '0;
        byte_cnt  = '0;
        phase     = SCAN_LEAD;
        err       = dtfp_pkg::ST_OK;
    endtask

    task automatic scan_char(input logic [7:0] c);
        logic        is_ws;
        logic [63:0] dig;
        is_ws = (c == " ") || (c == "\t");
        if (err != dtfp_pkg::ST_OK)
            return;
        if (phase == SCAN_LEAD) begin
            if (is_ws)
                return;
            phase = SCAN_BODY;
            if (c == "-" || c == "+") begin
                neg = (c == "-");
                return;
            end
        end else if (phase == SCAN_TRAIL) begin
            if (!is_ws)
                err = dtfp_pkg::ST_INVALID;
            return;
        end
        // body of the number
        if (is_ws) begin
            phase = SCAN_TRAIL;
            return;
        end
        if (c == "." && !seen_pt && has_whole && scale_cfg != 4'd0) begin
            seen_pt = 1'b1;
            return;
        end
        if (c < "0" || c > "9") begin
            err = dtfp_pkg::ST_INVALID;
            return;
        end
        if (seen_pt && frac_cnt >= scale_cfg) begin
            err = dtfp_pkg::ST_INVALID;
            return;
        end
        dig = 64'(c - 8'h30);
        if (mag > (sign_cap() - dig) / 64'd10) begin
            err = dtfp_pkg::ST_CAPACITY;
            return;
        end
        mag = mag * 64'd10 + dig;
        if (seen_pt)
            frac_cnt = frac_cnt + 4'd1;
        else
            has_whole = 1'b1;
    endtask

    function automatic parse_result_t close_text();
        parse_result_t r;
        logic [63:0]   lim;
        logic [63:0]   val;
        logic [3:0]    f;
        lim           = sign_cap();
        val           = mag;
        f             = frac_cnt;
        r.status      = dtfp_pkg::ST_OK;
        r.coefficient = '0;
        if (scale_cfg > dtfp_pkg::MAX_SCALE)
            r.status = dtfp_pkg::ST_INVALID;
        else if (byte_cnt > dtfp_pkg::MAX_TEXT_LENGTH)
            r.status = dtfp_pkg::ST_CAPACITY;
        else if (err != dtfp_pkg::ST_OK)
            r.status = err;
        else if (!has_whole || (seen_pt && f == 4'd0))
            r.status = dtfp_pkg::ST_INVALID;
        else begin
            // pad with zero digits up to the scale
            while (f < scale_cfg && r.status == dtfp_pkg::ST_OK) begin
                if (val > lim / 64'd10)
                    r.status = dtfp_pkg::ST_CAPACITY;
                else begin
                    val = val * 64'd10;
                    f   = f + 4'd1;
                end
            end
            if (r.status == dtfp_pkg::ST_OK)
                r.coefficient = neg ? -val : val;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t want;
        if (!rst_n) begin
            clear_text();
            scale_cfg  = 4'd0;
            mismatches = 0;
            parsed_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                scale_cfg = frac_scale;
            if (pop && !empty) begin
                if (parsed_q.size() == 0) begin
                    $display("%0t: unexpected word: status %0d coefficient %0d",
                             $time, status, coefficient);
                    mismatches++;
                end else begin
                    want = parsed_q.pop_front();
                    if (status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, status);
                        mismatches++;
                    end
                    if (coefficient !== want.coefficient) begin
                        $display("%0t: coefficient mismatch: expected %0d, got %0d",
                                 $time, want.coefficient, coefficient);
                        mismatches++;
                    end
                end
            end
            if (push && !full) begin
                if (byte_cnt != 8'hFF)
                    byte_cnt = byte_cnt + 8'd1;
                scan_char(text_byte);
                if (is_last) begin
                    parsed_q.push_back(close_text());
                    clear_text();
                end
            end
        end
        awaited = parsed_q.size();
    end

endmodule

@@ sim/tb_decimal_text_to_fixed_parser_top.sv @@
// Testbench top for decimal_text_to_fixed_parser_top: drives directed and random
// decimal texts and scale writes under varied idling. Needs dtfp_result_checker.
`timescale 1ns / 100ps

module tb_decimal_text_to_fixed_parser_top;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int SEG_BYTES     = 36;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               push       = 1'b0;
    logic               full;
    logic [7:0]         text_byte  = 8'h00;
    logic               is_last    = 1'b0;
    logic               empty;
    logic               pop        = 1'b0;
    logic [1:0]         status;
    logic signed [63:0] coefficient;
    logic               cfg_valid  = 1'b0;
    logic               cfg_ready;
    logic [3:0]         frac_scale = 4'd0;

    int mismatch_count;
    int results_awaited;
    int cycles        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int seg_bytes;

    logic [7:0] txt[$];
    logic [3:0] cur_scale;
    string      limit_digits = "9223372036854775807";
    string      noise_chars  = "0123456789.+- \t";

    // scale for each random segment, three per idling mode
    logic [3:0] seg_scales[9] = '{4'd9, 4'd0, 4'd4, 4'd1, 4'd9, 4'd6, 4'd0, 4'd2, 4'd7};

    decimal_text_to_fixed_parser_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .is_last     (is_last),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .coefficient (coefficient),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .frac_scale  (frac_scale)
    );

    dtfp_result_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .is_last     (is_last),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .coefficient (coefficient),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .frac_scale  (frac_scale),
        .mismatches  (mismatch_count),
        .awaited     (results_awaited)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
    endtask

    task automatic add_ws(input int n);
        repeat (n) txt.push_back($urandom_range(1) ? " " : "\t");
    endtask

    task automatic add_digits(input int n);
        repeat (n) txt.push_back(8'h30 + 8'($urandom_range(9)));
    endtask

    // Offer each byte of the text in turn; push stays high into the next text
    task automatic send_text();
        logic taken;
        for (int i = 0; i < txt.size(); i++) begin
            while ($urandom_range(99) < send_idle_pct) begin
                push <= 1'b0;
                @(posedge clk);
            end
            push      <= 1'b1;
            text_byte <= txt[i];
            is_last   <= (i == txt.size() - 1);
            do begin
                @(negedge clk);
                taken = !full;
                @(posedge clk);
            end while (!taken);
            seg_bytes++;
        end
        txt.delete();
    endtask

    task automatic send_str(input string s);
        add_str(s);
        send_text();
    endtask

    // Hold the sender until every result has been taken and the block is quiet
    task automatic settle();
        push <= 1'b0;
        do
            @(negedge clk);
        while (results_awaited != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_scale(input logic [3:0] s);
        logic taken;
        cfg_valid  <= 1'b1;
        frac_scale <= s;
        do begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
        cfg_valid <= 1'b0;
        cur_scale = s;
    endtask

    task automatic add_number();
        int k;
        int nf;
        add_ws($urandom_range(2));
        case ($urandom_range(2))
            0: txt.push_back("-");
            1: txt.push_back("+");
            default: ;
        endcase
        if ($urandom_range(4) == 0) begin
            // steer the magnitude round the signed 64-bit limit
            k = $urandom_range(15, 19);
            add_str(limit_digits.substr(0, k - 1));
            add_digits(19 - k + $urandom_range(1));
        end else
            add_digits($urandom_range(1, 6));
        if (cur_scale != 4'd0 && cur_scale <= 4'd9 && $urandom_range(1)) begin
            nf = ($urandom_range(9) == 0) ? cur_scale + 1 : $urandom_range(1, cur_scale);
            txt.push_back(".");
            add_digits(nf);
        end
        add_ws($urandom_range(2));
    endtask

    task automatic add_random_text();
        int pick;
        int pos;
        int len;
        pick = $urandom_range(99);
        if (pick < 65)
            add_number();
        else if (pick < 80) begin
            // break a well-formed number at one spot
            add_number();
            pos = $urandom_range(txt.size() - 1);
            case ($urandom_range(3))
                0: txt[pos] = 8'($urandom_range(255));
                1: txt.insert(pos, ".");
                2: txt.insert(pos, $urandom_range(1) ? "-" : "+");
                default: txt.insert(pos, " ");
            endcase
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(1))
                    txt.push_back(8'($urandom_range(255)));
                else
                    txt.push_back(noise_chars[$urandom_range(noise_chars.len() - 1)]);
            end
        end else begin
            // long text near the length limit, now and then past the count saturation
            len = ($urandom_range(3) == 0) ? $urandom_range(250, 262) : $urandom_range(60, 68);
            pos = $urandom_range(len - 1);
            add_ws(pos);
            add_digits(1);
            add_ws(len - pos - 1);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_idle_pct = 70;

        load_scale(4'd0);
        send_str("0");
        send_str("  -9223372036854775808\t");
        send_str("9223372036854775807");
        send_str("9223372036854775808");
        send_str("-9223372036854775809");
        send_str("+12 ");
        send_str("- 5");
        send_str("+-1");
        send_str("1.5");
        send_str(" \t ");
        send_str("1 2");
        send_str("12a");
        txt.push_back(8'h00);
        send_text();
        txt.push_back(8'hFF);
        send_text();
        add_ws(63);
        send_str("7");
        add_ws(64);
        send_str("7");
        add_str("x");
        add_ws(64);
        send_text();
        settle();

        load_scale(4'd9);
        send_str("922337203");
        send_str("9223372037");
        send_str("-922337203.6854775808");
        send_str("+0.000000001");
        send_str("1.1234567890");
        send_str("1.");
        send_str(".5");
        send_str("1.2.3");
        settle();

        // scale beyond the supported range
        load_scale(4'd15);
        send_str("1");
        settle();

        for (int m = 0; m < 3; m++) begin
            send_idle_pct = (m == 0) ? 7 : (m == 1) ? 70 : 0;
            recv_idle_pct = (m == 0) ? 70 : (m == 1) ? 7 : 0;
            for (int s = 0; s < 3; s++) begin
                load_scale(seg_scales[m * 3 + s]);
                seg_bytes = 0;
                while (seg_bytes < SEG_BYTES) begin
                    add_random_text();
                    send_text();
                end
                settle();
            end
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
